@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both macros disappear when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/msb_pkg.sv @@
`default_nettype none

package msb_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_WIDTH       = 32;
  localparam int OUT_WIDTH      = 32;
  localparam int QUEUE_DEPTH    = 4;

  // Tag of one queued element.
  typedef struct packed {
    logic is_last;
    logic keep;
  } ctl_t;

  // Back-end activity, seen by the top-level checks.
  typedef struct packed {
    logic sorting;
    logic emitting;
  } stat_t;

endpackage

`default_nettype wire

@@ src/msb_if.sv @@
`default_nettype none

interface msb_in_if import msb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] value;
  logic                       is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface msb_out_if import msb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] sorted_value;
  logic                        end_of_run;

  modport source (output valid, output sorted_value, output end_of_run, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, output ready);
endinterface

`default_nettype wire

@@ src/merge_sort_block.sv @@
`default_nettype none
// Channel  Dir  Payload                          Transfer
// in_ch    in   value[31:0] signed, is_last      valid && ready
// out_ch   out  sorted_value[31:0], end_of_run   valid && ready
//
// Loading: one element per cycle through a short queue; the queue keeps
// accepting while the sorter or the output register is busy, until it fills.
// Sorting: ceil(log2 n) bottom-up merge passes; each merge opens with a setup state (S_RUN),
// then per element a store read (S_RD) and one compare-and-write (S_CMP) through the read ports.
// Emission: per element a registered store read, then the output register.
// Reset (rst, synchronous) empties the queue and set; stores need no clearing.
// Either channel may stall at any cycle; results hold in the output register.

`include "assert_macros.svh"

module merge_sort_block import msb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);

  // Front to queue
  logic                  q_push;
  logic                  q_full;
  logic [DATA_WIDTH-1:0] q_push_data;
  ctl_t                  q_push_ctl;

  // Queue to back
  logic                  q_pop;
  logic                  q_valid;
  logic [DATA_WIDTH-1:0] q_pop_data;
  ctl_t                  q_pop_ctl;

  stat_t                 stat;

  // Classify: keep elements up to DEPTH, drop the rest, pass the closing flag.
  msb_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data),
    .q_ctl  (q_push_ctl)
  );

  // Decouple the input from the sorter.
  msb_queue #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .push_ctl  (q_push_ctl),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data),
    .pop_ctl   (q_pop_ctl)
  );

  // Store, merge-sort and emit the set.
  msb_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_ctl   (q_pop_ctl),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  // Never push into a full queue.
  `ASSERT_IMP(a_push_room, clk, rst, q_push, !q_full)
  // Pop only real entries.
  `ASSERT_IMP(a_pop_valid, clk, rst, q_pop, q_valid)
  // Hold the queue while a set is sorted or emitted.
  `ASSERT_IMP(a_hold_queue, clk, rst, stat.sorting || stat.emitting, !q_pop)
  // A pushed entry is visible next cycle.
  `ASSERT_NXT(a_push_lands, clk, rst, q_push, q_valid)

endmodule

`default_nettype wire

@@ src/msb_front.sv @@
`default_nettype none

module msb_front import msb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  msb_in_if.sink                in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [DATA_WIDTH-1:0] q_data,
  output ctl_t                  q_ctl
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt;
  logic          accept;
  logic          keep;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign keep        = cnt < CW'(DEPTH);

  // Drop elements past a full set; a closing element still goes through to start the sort.
  assign q_push        = accept && (keep || in_ch.is_last);
  assign q_ctl.is_last = in_ch.is_last;
  assign q_ctl.keep    = keep;

  generate
    if (DATA_WIDTH > IN_WIDTH) begin : g_wide
      assign q_data = {{(DATA_WIDTH - IN_WIDTH){in_ch.value[IN_WIDTH-1]}}, in_ch.value};
    end else if (DATA_WIDTH == IN_WIDTH) begin : g_same
      assign q_data = in_ch.value;
    end else begin : g_narrow
      assign q_data = in_ch.value[DATA_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      if (in_ch.is_last) begin
        cnt <= '0;
      end else if (keep) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/msb_queue.sv @@
`default_nettype none

module msb_queue import msb_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  ctl_t                  push_ctl,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] pop_data,
  output ctl_t                  pop_ctl
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  logic [DATA_WIDTH-1:0] data_q [QUEUE_DEPTH];
  ctl_t                  ctl_q  [QUEUE_DEPTH];
  logic [QAW-1:0]        wr_ptr;
  logic [QAW-1:0]        rd_ptr;
  logic [QAW:0]          count;

  assign full     = count == (QAW+1)'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_data = data_q[rd_ptr];
  assign pop_ctl  = ctl_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      data_q[wr_ptr] <= push_data;
      ctl_q[wr_ptr]  <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/msb_back.sv @@
`default_nettype none

module msb_back import msb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [DATA_WIDTH-1:0] q_data,
  input  ctl_t                  q_ctl,
  output logic                  q_pop,
  output stat_t                 stat,
  msb_out_if.source             out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = CW + 2;

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_START   = 7'b0000010,
    S_RUN     = 7'b0000100,
    S_RD      = 7'b0001000,
    S_CMP     = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_WR = 7'b1000000
  } state_t;

  state_t state;

  logic [CW-1:0] cnt;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [SW-1:0] w;
  logic [SW-1:0] lo;
  logic [SW-1:0] ia;
  logic [SW-1:0] ib;
  logic [SW-1:0] a_end;
  logic [SW-1:0] b_end;
  logic [SW-1:0] k;
  logic          dir;

  logic                  out_valid;
  logic [OUT_WIDTH-1:0]  out_data;
  logic                  out_eor;
  logic                  out_load;

  // Two ping-pong stores, each with one write and two registered reads.
  logic [DATA_WIDTH-1:0] store_mem [DEPTH];
  logic [DATA_WIDTH-1:0] buf_mem   [DEPTH];
  logic [DATA_WIDTH-1:0] sa_q, sb_q, ba_q, bb_q;
  logic [DATA_WIDTH-1:0] rda, rdb, pick;
  logic [AW-1:0]         rd_a, rd_b, store_wa;
  logic [DATA_WIDTH-1:0] store_wd;
  logic                  store_we, buf_we;
  logic                  a_ok, b_ok, take_a;
  logic [SW-1:0]         nx, w2, mid_s, hi_s, mid_c, hi_c;
  logic [OUT_WIDTH-1:0]  out_conv;

  assign nx    = SW'(n);
  assign w2    = w << 1;
  assign mid_s = lo + w;
  assign hi_s  = lo + w2;
  assign mid_c = (mid_s < nx) ? mid_s : nx;
  assign hi_c  = (hi_s < nx) ? hi_s : nx;

  // dir low: runs live in store_mem and merge into buf_mem.
  assign rda    = dir ? ba_q : sa_q;
  assign rdb    = dir ? bb_q : sb_q;
  assign a_ok   = ia < a_end;
  assign b_ok   = ib < b_end;
  assign take_a = a_ok && (!b_ok || ($signed(rda) < $signed(rdb)));
  assign pick   = take_a ? rda : rdb;

  // Hold the emit address while the output register waits.
  assign rd_a     = ((state == S_EMIT_RD) || (state == S_EMIT_WR)) ? i[AW-1:0] : ia[AW-1:0];
  assign rd_b     = ib[AW-1:0];
  assign q_pop    = (state == S_LOAD) && q_valid;
  assign store_we = (q_pop && q_ctl.keep) || ((state == S_CMP) && dir);
  assign store_wa = (state == S_LOAD) ? cnt[AW-1:0] : k[AW-1:0];
  assign store_wd = (state == S_LOAD) ? q_data : pick;
  assign buf_we   = (state == S_CMP) && !dir;
  assign out_load = (state == S_EMIT_WR) && (!out_valid || out_ch.ready);

  assign stat.sorting  = (state == S_START) || (state == S_RUN) || (state == S_RD) ||
                         (state == S_CMP);
  assign stat.emitting = (state == S_EMIT_RD) || (state == S_EMIT_WR);

  generate
    if (DATA_WIDTH > OUT_WIDTH) begin : g_wide
      assign out_conv = rda[OUT_WIDTH-1:0];
    end else if (DATA_WIDTH == OUT_WIDTH) begin : g_same
      assign out_conv = rda;
    end else begin : g_narrow
      assign out_conv = {{(OUT_WIDTH - DATA_WIDTH){1'b0}}, rda};
    end
  endgenerate

  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_data;
  assign out_ch.end_of_run   = out_eor;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    sa_q <= store_mem[rd_a];
    sb_q <= store_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[k[AW-1:0]] <= pick;
    end
    ba_q <= buf_mem[rd_a];
    bb_q <= buf_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            if (q_ctl.keep) begin
              cnt <= cnt + CW'(1);
            end
            if (q_ctl.is_last) begin
              n     <= cnt + CW'(q_ctl.keep);
              state <= S_START;
            end
          end
        end
        S_START: begin
          w   <= SW'(1);
          lo  <= '0;
          dir <= 1'b0;
          i   <= '0;
          state <= (n == CW'(1)) ? S_EMIT_RD : S_RUN;
        end
        S_RUN: begin
          ia    <= lo;
          ib    <= mid_c;
          a_end <= mid_c;
          b_end <= hi_c;
          k     <= lo;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (take_a) begin
            ia <= ia + SW'(1);
          end else begin
            ib <= ib + SW'(1);
          end
          k <= k + SW'(1);
          if (k + SW'(1) == b_end) begin
            if (hi_s >= nx) begin
              dir <= !dir;
              w   <= w2;
              lo  <= '0;
              state <= (w2 >= nx) ? S_EMIT_RD : S_RUN;
            end else begin
              lo    <= hi_s;
              state <= S_RUN;
            end
          end else begin
            state <= S_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_load) begin
            out_data  <= out_conv;
            out_eor   <= (i + CW'(1) == n);
            if (i + CW'(1) == n) begin
              cnt   <= '0;
              state <= S_LOAD;
            end else begin
              i     <= i + CW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
  import msb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Receiver hold-off length for the back-pressure stretch, in cycles.
  localparam int HOLD_CYCLES = 400;
  // Cycles to idle after the last result.
  localparam int SETTLE_CYCLES = 1100;

  localparam logic signed [IN_WIDTH-1:0] MIN_VAL = {1'b1, {(IN_WIDTH-1){1'b0}}};
  localparam logic signed [IN_WIDTH-1:0] MAX_VAL = {1'b0, {(IN_WIDTH-1){1'b1}}};
  localparam logic signed [IN_WIDTH-1:0] ALT_LO  = 32'sh5555_5555;
  localparam logic signed [IN_WIDTH-1:0] ALT_HI  = 32'shAAAA_AAAA;

  // How the values of one random set are drawn.
  typedef enum int {VALS_WIDE, VALS_NARROW, VALS_EXTREME} value_mix_e;

  // One emitted element as the sorter should present it.
  typedef struct {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        last;
  } sorted_elem_t;

  // Tracks the set being gathered and the sorted elements still owed.
  class sorted_set_tracker;
    logic signed [IN_WIDTH-1:0] held[$];
    sorted_elem_t               owed[$];

    // Store the element unless the set is full; on the closing flag,
    // sort what is held and queue it for emission.
    function void note_element(logic signed [IN_WIDTH-1:0] v, logic last);
      logic signed [IN_WIDTH-1:0] ordered[$];
      sorted_elem_t               e;
      int                         j;
      if (held.size() < DEPTH_DEF) held.push_back(v);
      if (!last) return;
      foreach (held[i]) begin
        j = ordered.size();
        while (j > 0 && ordered[j-1] > held[i]) j--;
        ordered.insert(j, held[i]);
      end
      foreach (ordered[i]) begin
        e.value = ordered[i];
        e.last  = (i == ordered.size() - 1);
        owed.push_back(e);
      end
      held.delete();
    endfunction

    // Compare one emitted element with the oldest one owed.
    function bit check_emitted(logic signed [OUT_WIDTH-1:0] v, logic last,
                               output string msg);
      sorted_elem_t e;
      if (owed.size() == 0) begin
        msg = $sformatf("unexpected element %0d end_of_run=%0b", v, last);
        return 1'b0;
      end
      e = owed.pop_front();
      if (v !== e.value || last !== e.last) begin
        msg = $sformatf("got %0d end_of_run=%0b, want %0d end_of_run=%0b",
                        v, last, e.value, e.last);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  msb_in_if  in_ch();
  msb_out_if out_ch();

  merge_sort_block dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_set_tracker tracker;
  int                mismatches   = 0;
  int                idle_pct     = 0;   // sender idle chance, percent
  int                stall_pct    = 0;   // receiver stall chance, percent
  bit                hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run: far beyond any correct run.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Record every accepted input transaction, sampled at the edge that
  // moves it.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      tracker.note_element(in_ch.value, in_ch.is_last);
  end

  // Check every accepted output transaction against the oldest owed element.
  always @(posedge clk) begin
    string msg;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (!tracker.check_emitted(out_ch.sorted_value, out_ch.end_of_run, msg))
        report_mismatch(msg);
    end
  end

  // Receiver: stall at random; on request, hold ready low for a long
  // stretch counted here, so the block backs up and stalls its input.
  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one set, flagging its final element; idle at random between
  // transactions. Valid stays high from the offer until the item is accepted.
  task automatic send_set(input logic signed [IN_WIDTH-1:0] vals[$]);
    foreach (vals[i]) begin
      while ($urandom_range(99) < idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.value   <= vals[i];
      in_ch.is_last <= (i == vals.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
    end
  endtask

  // Drop valid and hold the sender until every owed element has come out.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_WIDTH-1:0] pick_value(value_mix_e mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      VALS_NARROW: return int'($urandom_range(6)) - 3;
      VALS_EXTREME: begin
        if (r < 25) return MIN_VAL;
        if (r < 50) return MAX_VAL;
        if (r < 65) return '0;
        if (r < 80) return '1;
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // Build a random set: mostly short, now and then full or overflowing
  // so the closing element gets dropped.
  task automatic make_random_set(output logic signed [IN_WIDTH-1:0] vals[$]);
    int         size;
    value_mix_e mix;
    vals.delete();
    if ($urandom_range(99) < 8) size = DEPTH_DEF + $urandom_range(4);
    else size = 1 + $urandom_range(11);
    case ($urandom_range(2))
      0:       mix = VALS_NARROW;
      1:       mix = VALS_EXTREME;
      default: mix = VALS_WIDE;
    endcase
    repeat (size) vals.push_back(pick_value(mix));
  endtask

  initial begin : stimulus
    logic signed [IN_WIDTH-1:0] vals[$];
    int                         phase_items;
    tracker = new();
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.is_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed sets, no idling: single-element sets at both extremes,
    // a mixed set of extremes and alternating bit patterns, equal keys,
    // and a set arriving in descending order.
    vals = {MAX_VAL};
    send_set(vals);
    vals = {MIN_VAL};
    send_set(vals);
    vals = {32'sd0, -32'sd1, MAX_VAL, MIN_VAL, 32'sd1, MAX_VAL, MIN_VAL,
            ALT_LO, ALT_HI, -32'sd1};
    send_set(vals);
    vals = {32'sd7, 32'sd7, -32'sd7, 32'sd7};
    send_set(vals);
    vals = {32'sd100, 32'sd50, 32'sd0, -32'sd50, -32'sd100};
    send_set(vals);
    wait_for_drain();

    // Random phases: none idle, sender idle, receiver stalling, both.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase

      if (p == 0) begin
        // Hold off the receiver while a short set and an overflowing set
        // are offered back to back; the block must fill and stall input.
        hold_request = 1'b1;
        vals = {32'sd3, -32'sd2, 32'sd3};
        send_set(vals);
        vals.delete();
        repeat (DEPTH_DEF + 2) vals.push_back($urandom);
        send_set(vals);
        wait_for_drain();
      end

      phase_items = 0;
      while (phase_items < 60) begin
        make_random_set(vals);
        send_set(vals);
        phase_items += vals.size();
      end
      wait_for_drain();
    end

    // Let any late activity show up, then flag owed elements never emitted.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0)
      report_mismatch($sformatf("%0d sorted elements never emitted",
                                tracker.outstanding()));

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
